/* rtl/vertex_center_and_scale_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the vertex center and scale RTL
// ---------------------------------------------------------------------------
`ifndef VERTEX_CENTER_AND_SCALE_MACROS_SVH
`define VERTEX_CENTER_AND_SCALE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define VCS_ASSERT_IMPL(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("vcs: implication check failed");

// Next-cycle implication, sampled on clk, off during rst
`define VCS_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("vcs: next-cycle check failed");

`endif

/* rtl/vcs_pkg.sv */
// ---------------------------------------------------------------------------
// vcs_pkg
// Types, codes and helpers of the vertex center and scale block.
// ---------------------------------------------------------------------------
`default_nettype none

package vcs_pkg;

  localparam int MAX_VERTICES_DEF  = 1024;
  localparam int COORD_W           = 32;
  localparam int TEXT_W            = 24;
  localparam logic [TEXT_W-1:0] TARGET_EXTENT_RST = 24'd655360;
  // Signed (coordinate - center) times target extent
  localparam int PROD_W            = COORD_W + 1 + TEXT_W;
  localparam int EXT_W             = COORD_W;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef struct packed {
    op_t                       op;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    status_t                   status;
    logic                      dropped;
    logic                      last;
  } out_item_t;

  // Clamp a wide quotient to the signed coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [PROD_W-1:0] v
  );
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - PROD_W'(1);
    if (v > hi) begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/vcs_ram.sv */
// ---------------------------------------------------------------------------
// vcs_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module vcs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/vcs_queue.sv */
// ---------------------------------------------------------------------------
// vcs_queue
// Two-entry queue of request transactions between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module vcs_queue #(
  parameter int W = 14
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);

  logic [W-1:0] slot [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   fill;

  assign full     = fill == 2'd2;
  assign empty    = fill == 2'd0;
  assign pop_data = slot[rptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= !wptr;
      end
      if (pop && !empty) begin
        rptr <= !rptr;
      end
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  // Hold entry payload
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/vcs_div.sv */
// ---------------------------------------------------------------------------
// vcs_div
// Radix-2 restoring divider, signed numerator, positive divisor, one quotient
// bit per cycle, truncation toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module vcs_div #(
  parameter int NUM_W = 57,
  parameter int DEN_W = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0]        den,
  output logic                         done,
  output logic signed [NUM_W-1:0]      quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             neg;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;

  assign trial     = {rem_r, quo_r[NUM_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign fits      = trial >= {1'b0, den_r};
  assign quo       = neg ? -$signed(quo_r) : $signed(quo_r);

  // Control: count down one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in numerator bits, subtract where the divisor fits
  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[NUM_W-1];
      quo_r <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem_r <= '0;
      den_r <= den;
    end else if (busy) begin
      rem_r <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

/* rtl/vcs_front.sv */
// ---------------------------------------------------------------------------
// vcs_front
// Accepts transactions, keeps per-axis statistics, writes the vertex store and
// queues emit requests with their position and flags resolved.
// ---------------------------------------------------------------------------
`default_nettype none

module vcs_front
  import vcs_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  localparam int AW    = $clog2(MAX_VERTICES),
  localparam int CNT_W = $clog2(MAX_VERTICES + 1),
  localparam int SUM_W = COORD_W + CNT_W,
  localparam int E_W   = AW + 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire in_item_t                   in_data,
  output logic                            ram_we,
  output logic [AW-1:0]                   ram_addr,
  output logic [3*COORD_W-1:0]            ram_wdata,
  output logic                            q_push,
  output logic [E_W-1:0]                  q_data,
  input  wire logic                       q_full,
  input  wire logic                       q_empty,
  input  wire logic                       back_idle,
  output logic signed [SUM_W-1:0]         axis_sum  [3],
  output logic signed [COORD_W-1:0]       axis_low  [3],
  output logic signed [COORD_W-1:0]       axis_high [3],
  output logic [CNT_W-1:0]                vertex_count
);

  logic                      emitting;
  logic                      overflow;
  logic [CNT_W-1:0]          emit_pos;
  logic                      is_load;
  logic                      load_ok;
  logic                      accept;
  logic [CNT_W-1:0]          base_count;
  logic                      at_cap;
  logic signed [COORD_W-1:0] c [3];
  logic [CNT_W-1:0]          pos;
  logic                      none_left;
  logic                      is_last;

  assign is_load = in_data.op == OP_LOAD;
  // A load that opens a new set waits until emission has drained
  assign load_ok  = !emitting || (q_empty && back_idle);
  assign in_ready = is_load ? load_ok : !q_full;
  assign accept   = in_valid && in_ready;

  assign c[0] = in_data.pos_x;
  assign c[1] = in_data.pos_y;
  assign c[2] = in_data.pos_z;

  assign base_count = emitting ? '0 : vertex_count;
  assign at_cap     = base_count >= CNT_W'(MAX_VERTICES);

  // Store write
  assign ram_we    = accept && is_load && !at_cap;
  assign ram_addr  = base_count[AW-1:0];
  assign ram_wdata = {in_data.pos_x, in_data.pos_y, in_data.pos_z};

  // Resolve the request position and flags
  assign pos       = emitting ? emit_pos : '0;
  assign none_left = pos >= vertex_count;
  assign is_last   = !none_left && ((pos + CNT_W'(1)) == vertex_count);
  assign q_push    = accept && !is_load;
  assign q_data    = {!emitting, none_left, is_last, overflow, pos[AW-1:0]};

  // Update set state
  always_ff @(posedge clk) begin
    if (rst) begin
      emitting     <= 1'b0;
      overflow     <= 1'b0;
      emit_pos     <= '0;
      vertex_count <= '0;
      for (int a = 0; a < 3; a++) begin
        axis_sum[a]  <= '0;
        axis_low[a]  <= {1'b0, {(COORD_W-1){1'b1}}};
        axis_high[a] <= {1'b1, {(COORD_W-1){1'b0}}};
      end
    end else if (accept && is_load) begin
      if (emitting) begin
        // Start a new set with this vertex
        emitting     <= 1'b0;
        overflow     <= 1'b0;
        emit_pos     <= '0;
        vertex_count <= CNT_W'(1);
        for (int a = 0; a < 3; a++) begin
          axis_sum[a]  <= SUM_W'(c[a]);
          axis_low[a]  <= c[a];
          axis_high[a] <= c[a];
        end
      end else if (at_cap) begin
        overflow <= 1'b1;
      end else begin
        vertex_count <= vertex_count + CNT_W'(1);
        for (int a = 0; a < 3; a++) begin
          axis_sum[a] <= axis_sum[a] + SUM_W'(c[a]);
          if (c[a] < axis_low[a]) begin
            axis_low[a] <= c[a];
          end
          if (c[a] > axis_high[a]) begin
            axis_high[a] <= c[a];
          end
        end
      end
    end else if (accept) begin
      emitting <= 1'b1;
      emit_pos <= none_left ? pos : pos + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

/* rtl/vcs_back.sv */
// ---------------------------------------------------------------------------
// vcs_back
// Executes queued emit requests: computes centers and the largest extent once
// per set, then scales each stored vertex through a shared divider.
// ---------------------------------------------------------------------------
`default_nettype none

`include "vertex_center_and_scale_macros.svh"

module vcs_back
  import vcs_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  localparam int AW    = $clog2(MAX_VERTICES),
  localparam int CNT_W = $clog2(MAX_VERTICES + 1),
  localparam int SUM_W = COORD_W + CNT_W,
  localparam int E_W   = AW + 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  output logic                            q_pop,
  input  wire logic [E_W-1:0]             q_data,
  input  wire logic signed [SUM_W-1:0]    axis_sum  [3],
  input  wire logic signed [COORD_W-1:0]  axis_low  [3],
  input  wire logic signed [COORD_W-1:0]  axis_high [3],
  input  wire logic [CNT_W-1:0]           vertex_count,
  input  wire logic [TEXT_W-1:0]          target_extent,
  output logic                            ram_re,
  output logic [AW-1:0]                   ram_raddr,
  input  wire logic [3*COORD_W-1:0]       ram_rdata,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output out_item_t                       out_data,
  output logic                            idle
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CDIV  = 6'b000010,
    S_DISP  = 6'b000100,
    S_FETCH = 6'b001000,
    S_MUL   = 6'b010000,
    S_SDIV  = 6'b100000
  } state_t;

  state_t                     state;
  logic                       emit_pend;
  logic                       e_none;
  logic                       e_last;
  logic                       e_drop;
  logic [AW-1:0]              e_idx;
  logic [1:0]                 axis;
  logic [1:0]                 axis_inc;
  logic signed [COORD_W-1:0]  center [3];
  logic signed [COORD_W-1:0]  vtx    [3];
  logic signed [COORD_W-1:0]  res    [3];
  status_t                    res_st;
  logic [EXT_W-1:0]           extent;
  logic [EXT_W-1:0]           extent_calc;
  logic signed [COORD_W:0]    span [3];
  logic signed [PROD_W-1:0]   div_num;
  logic [EXT_W-1:0]           div_den;
  logic                       div_start;
  logic                       div_done;
  logic signed [PROD_W-1:0]   div_quo;
  logic signed [COORD_W:0]    diff;
  logic signed [PROD_W:0]     prod;
  logic                       out_free;

  vcs_div #(
    .NUM_W (PROD_W),
    .DEN_W (EXT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign idle     = state == S_IDLE && !emit_pend;
  assign axis_inc = axis + 2'd1;
  assign out_free = !out_valid || out_ready;
  assign q_pop    = state == S_IDLE && !emit_pend && q_valid;

  // Largest axis extent, never below zero
  always_comb begin
    extent_calc = '0;
    for (int a = 0; a < 3; a++) begin
      span[a] = {axis_high[a][COORD_W-1], axis_high[a]}
              - {axis_low[a][COORD_W-1], axis_low[a]};
      if (span[a] > $signed({1'b0, extent_calc})) begin
        extent_calc = span[a][EXT_W-1:0];
      end
    end
  end

  // Centered coordinate times target extent
  assign diff = {vtx[axis][COORD_W-1], vtx[axis]}
              - {center[axis][COORD_W-1], center[axis]};
  assign prod = diff * $signed({1'b0, target_extent});

  // Read the store entry of the request
  assign ram_re    = state == S_DISP && !e_none && extent != '0;
  assign ram_raddr = e_idx;

  // Sequence one request
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      emit_pend <= 1'b0;
      div_start <= 1'b0;
      axis      <= '0;
      extent    <= '0;
      for (int a = 0; a < 3; a++) begin
        center[a] <= '0;
      end
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (emit_pend) begin
            if (out_free) begin
              emit_pend <= 1'b0;
            end
          end else if (q_valid) begin
            {e_none, e_last, e_drop, e_idx} <= q_data[E_W-2:0];
            if (q_data[E_W-1]) begin
              extent <= extent_calc;
              if (vertex_count == '0) begin
                for (int a = 0; a < 3; a++) begin
                  center[a] <= '0;
                end
                state <= S_DISP;
              end else begin
                axis      <= '0;
                div_num   <= PROD_W'(axis_sum[0]);
                div_den   <= EXT_W'(vertex_count);
                div_start <= 1'b1;
                state     <= S_CDIV;
              end
            end else begin
              state <= S_DISP;
            end
          end
        end
        S_CDIV: begin
          if (div_done) begin
            center[axis] <= div_quo[COORD_W-1:0];
            if (axis == 2'd2) begin
              state <= S_DISP;
            end else begin
              axis      <= axis_inc;
              div_num   <= PROD_W'(axis_sum[axis_inc]);
              div_start <= 1'b1;
            end
          end
        end
        S_DISP: begin
          if (e_none || extent == '0) begin
            for (int a = 0; a < 3; a++) begin
              res[a] <= '0;
            end
            res_st    <= e_none ? ST_NONE : ST_ZERO;
            emit_pend <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          vtx[0] <= ram_rdata[3*COORD_W-1:2*COORD_W];
          vtx[1] <= ram_rdata[2*COORD_W-1:COORD_W];
          vtx[2] <= ram_rdata[COORD_W-1:0];
          axis   <= '0;
          state  <= S_MUL;
        end
        S_MUL: begin
          div_num   <= prod[PROD_W-1:0];
          div_den   <= extent;
          div_start <= 1'b1;
          state     <= S_SDIV;
        end
        S_SDIV: begin
          if (div_done) begin
            res[axis] <= sat_coord(div_quo);
            if (axis == 2'd2) begin
              res_st    <= ST_OK;
              emit_pend <= 1'b1;
              state     <= S_IDLE;
            end else begin
              axis  <= axis_inc;
              state <= S_MUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_IDLE && emit_pend && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && emit_pend && out_free) begin
      out_data.out_x   <= res[0];
      out_data.out_y   <= res[1];
      out_data.out_z   <= res[2];
      out_data.status  <= res_st;
      out_data.dropped <= e_drop;
      out_data.last    <= e_last;
    end
  end

  // Checks
  `VCS_ASSERT_NEXT(a_div_start_done, div_start, !div_done)
  `VCS_ASSERT_IMPL(a_fetch_after_read, state == S_FETCH, $past(ram_re))
  `VCS_ASSERT_IMPL(a_no_pop_busy, q_pop, state == S_IDLE && !emit_pend)

endmodule

`default_nettype wire

/* rtl/vertex_center_and_scale.sv */
// ---------------------------------------------------------------------------
// vertex_center_and_scale
// Bounding-box normalization of a set of signed Q16.16 vertices.
// ---------------------------------------------------------------------------
//  Channel   Signals                        Moves
//  input     in_valid/in_ready, in_data     load or emit request
//  output    out_valid/out_ready, out_data  one normalized vertex per request
//  config    cfg_wr_en, cfg_wr_data         target_extent, no wait
//
//  The first request of a set computes the per-axis centers in the shared
//  serial divider; each request then scales its vertex with three 57-bit
//  divisions. Status-only results skip the scaling divisions. A load that
//  opens a new set waits until queued requests are done. Reset: sync,
//  active high, no sweep.
// ---------------------------------------------------------------------------
`default_nettype none

`include "vertex_center_and_scale_macros.svh"

module vertex_center_and_scale
  import vcs_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [TEXT_W-1:0] cfg_wr_data
);

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W = COORD_W + CNT_W;
  localparam int E_W   = AW + 4;

  logic [TEXT_W-1:0]         target_extent;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [3*COORD_W-1:0]      ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [3*COORD_W-1:0]      ram_rdata;
  logic                      q_push;
  logic [E_W-1:0]            q_wdata;
  logic                      q_full;
  logic                      q_pop;
  logic [E_W-1:0]            q_rdata;
  logic                      q_empty;
  logic                      back_idle;
  logic signed [SUM_W-1:0]   axis_sum  [3];
  logic signed [COORD_W-1:0] axis_low  [3];
  logic signed [COORD_W-1:0] axis_high [3];
  logic [CNT_W-1:0]          vertex_count;
  logic                      load_accept;
  logic                      none_zero;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_extent <= TARGET_EXTENT_RST;
    end else if (cfg_wr_en) begin
      target_extent <= cfg_wr_data;
    end
  end

  vcs_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .ram_we       (ram_we),
    .ram_addr     (ram_waddr),
    .ram_wdata    (ram_wdata),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_full       (q_full),
    .q_empty      (q_empty),
    .back_idle    (back_idle),
    .axis_sum     (axis_sum),
    .axis_low     (axis_low),
    .axis_high    (axis_high),
    .vertex_count (vertex_count)
  );

  vcs_queue #(
    .W (E_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  vcs_ram #(
    .WIDTH (3 * COORD_W),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vcs_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (!q_empty),
    .q_pop         (q_pop),
    .q_data        (q_rdata),
    .axis_sum      (axis_sum),
    .axis_low      (axis_low),
    .axis_high     (axis_high),
    .vertex_count  (vertex_count),
    .target_extent (target_extent),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .idle          (back_idle)
  );

  // Check terms
  assign load_accept = in_valid && in_ready && in_data.op == OP_LOAD;
  assign none_zero   = out_data.out_x == '0 && out_data.out_y == '0
                    && out_data.out_z == '0 && !out_data.last;

  // Checks
  `VCS_ASSERT_IMPL(a_load_when_drained, load_accept, q_empty && back_idle)
  `VCS_ASSERT_IMPL(a_none_is_zero, out_valid && out_data.status == ST_NONE, none_zero)
  `VCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

`default_nettype wire
